// ===== rtl/glu_pkg.sv =====
// Package for the GCD / LCM unit: request and response words, the
// control and status groups between top level and core, and mode codes.
// No dependencies.
`timescale 1ns / 1ps

package glu_pkg;

  localparam int unsigned OPERAND_W = 32;
  localparam int unsigned RESULT_W  = 64;

  localparam logic MODE_GCD = 1'b0;
  localparam logic MODE_LCM = 1'b1;

  typedef struct packed {
    logic [OPERAND_W-1:0] first_value;
    logic [OPERAND_W-1:0] second_value;
    logic                 mode;
  } glu_req_t;

  typedef struct packed {
    logic [RESULT_W-1:0] result_value;
    logic                zero_operand;
  } glu_rsp_t;

  // top level -> core
  typedef struct packed {
    logic start;  // request word accepted this cycle
    logic take;   // output register can load the result
  } glu_ctrl_t;

  // core -> top level
  typedef struct packed {
    logic idle;   // core can take a new word
    logic done;   // result word is on the core output
  } glu_stat_t;

endpackage

// ===== rtl/glu_sub.sv =====
// Shared subtract / compare unit of the GCD / LCM unit.
// Depends on nothing; width set by parameter.
`timescale 1ns / 1ps

module glu_sub #(
  parameter int unsigned W = 33
) (
  input  logic [W-1:0] op_a,
  input  logic [W-1:0] op_b,
  output logic [W-1:0] diff,
  output logic         borrow
);

  assign {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};

endmodule

// ===== rtl/glu_core.sv =====
// Sequencer and datapath registers of the GCD / LCM unit: binary GCD,
// restoring division of the first operand by the divisor, final product.
// Depends on glu_pkg and glu_sub.
`timescale 1ns / 1ps

module glu_core #(
  parameter int unsigned WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  glu_pkg::glu_ctrl_t ctrl,
  input  glu_pkg::glu_req_t  req,
  output glu_pkg::glu_stat_t stat,
  output glu_pkg::glu_rsp_t  rsp
);

  localparam int unsigned KW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TWO  = 3'd1;
  localparam logic [2:0] S_RED  = 3'd2;
  localparam logic [2:0] S_SHL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]       state;
  logic [WIDTH-1:0] x;        // GCD working value, then the divisor
  logic [WIDTH-1:0] y;        // GCD working value, then the remainder
  logic [WIDTH-1:0] a_keep;   // first operand, then the quotient
  logic [WIDTH-1:0] b_keep;
  logic [KW-1:0]    k;        // common power of two
  logic [KW-1:0]    cnt;
  logic             mode;
  logic             zero;

  logic [WIDTH:0]   op_a;
  logic [WIDTH:0]   op_b;
  logic [WIDTH:0]   diff;
  logic             borrow;

  logic [WIDTH-1:0]   a_in;
  logic [WIDTH-1:0]   b_in;
  logic [2*WIDTH-1:0] prod;

  assign a_in = req.first_value[WIDTH-1:0];
  assign b_in = req.second_value[WIDTH-1:0];

  always_comb begin
    if (state == S_DIV) begin
      op_a = {y, a_keep[WIDTH-1]};
      op_b = {1'b0, x};
    end else begin
      op_a = {1'b0, x};
      op_b = {1'b0, y};
    end
  end

  glu_sub #(
    .W (WIDTH + 1)
  ) u_sub (
    .op_a   (op_a),
    .op_b   (op_b),
    .diff   (diff),
    .borrow (borrow)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctrl.start) begin
            mode   <= req.mode;
            b_keep <= b_in;
            k      <= '0;
            if (a_in == '0 || b_in == '0) begin
              // zero operand: divisor is the other one, multiple is zero
              zero   <= 1'b1;
              x      <= a_in | b_in;
              a_keep <= '0;
              state  <= S_FIN;
            end else begin
              zero   <= 1'b0;
              x      <= a_in;
              y      <= b_in;
              a_keep <= a_in;
              state  <= S_TWO;
            end
          end
        end
        S_TWO: begin
          if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + 1'b1;
          end else begin
            state <= S_RED;
          end
        end
        S_RED: begin
          if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (diff == '0) begin
            state <= S_SHL;
          end else if (!borrow) begin
            x <= diff[WIDTH-1:0];
          end else begin
            // x below y: swap and subtract next cycle
            x <= y;
            y <= x;
          end
        end
        S_SHL: begin
          if (k == '0) begin
            y     <= '0;
            cnt   <= KW'(WIDTH - 1);
            state <= (mode == glu_pkg::MODE_LCM) ? S_DIV : S_FIN;
          end else begin
            x <= x << 1;
            k <= k - 1'b1;
          end
        end
        S_DIV: begin
          y      <= borrow ? op_a[WIDTH-1:0] : diff[WIDTH-1:0];
          a_keep <= {a_keep[WIDTH-2:0], ~borrow};
          cnt    <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (ctrl.take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign prod = a_keep * b_keep;

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_FIN);

  assign rsp.result_value = (mode == glu_pkg::MODE_LCM) ? glu_pkg::RESULT_W'(prod)
                                                        : glu_pkg::RESULT_W'(x);
  assign rsp.zero_operand = zero;

  a_red_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_RED |-> (x != '0 && y != '0))
    else $error("GCD operand reached zero during reduction");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> x != '0)
    else $error("division by zero divisor");

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && ctrl.start) |=> state != S_IDLE)
    else $error("accepted word did not start the sequencer");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !ctrl.take) |=> (state == S_FIN && $stable(rsp)))
    else $error("result dropped or changed while output register busy");

endmodule

// ===== rtl/gcd_lcm_unit.sv =====
// Top level of the GCD / LCM unit: request handshake, output register.
// Depends on glu_pkg and glu_core.
//
//   channel | signals                     | word type
//   --------+-----------------------------+------------------
//   request | req_valid, req_ready, req   | glu_pkg::glu_req_t
//   response| rsp_valid, rsp_ready, rsp   | glu_pkg::glu_rsp_t
//
// One word at a time; it holds the core from acceptance until its result enters
// the output register: straight to the finish with a zero operand, otherwise
// through the binary GCD loop (one shift, subtract or swap per cycle on the
// shared subtractor), plus WIDTH division steps for an LCM.
// req_ready is high only while the core is idle; a waiting response does not
// block a new request, but the core holds a finished result until the
// output register is free. Synchronous reset clears all handshake state.
`timescale 1ns / 1ps

module gcd_lcm_unit #(
  parameter int unsigned WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  glu_pkg::glu_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output glu_pkg::glu_rsp_t rsp
);

  glu_pkg::glu_ctrl_t ctrl;
  glu_pkg::glu_stat_t stat;
  glu_pkg::glu_rsp_t  core_rsp;

  assign req_ready  = stat.idle;
  assign ctrl.start = req_valid && req_ready;
  assign ctrl.take  = !rsp_valid || rsp_ready;

  glu_core #(
    .WIDTH (WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .req  (req),
    .stat (stat),
    .rsp  (core_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (stat.done && ctrl.take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // load the result word when the register is free
  always_ff @(posedge clk) begin
    if (stat.done && ctrl.take) begin
      rsp <= core_rsp;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for gcd_lcm_unit: queued request words, a clocked driver and
// monitor, and a predictor that computes divisor and multiple directly.
// Depends on glu_pkg and the gcd_lcm_unit RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned WIDTH = 32;
  localparam logic [63:0] OPERAND_MASK = (64'd1 << WIDTH) - 64'd1;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned DRAIN_CYCLES = 400;

  typedef enum logic [1:0] {READY_ALWAYS, READY_MOSTLY, READY_SPARSE} ready_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  glu_pkg::glu_req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  glu_pkg::glu_rsp_t rsp;

  glu_pkg::glu_req_t pending_words[$];
  glu_pkg::glu_rsp_t expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;

  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 200;
  int unsigned style_span = 0;
  ready_style_t ready_style = READY_ALWAYS;

  gcd_lcm_unit #(.WIDTH(WIDTH)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Divisor by remainders (same value as repeated subtraction), multiple from it.
  function automatic glu_pkg::glu_rsp_t gcd_or_lcm(glu_pkg::glu_req_t w);
    logic [63:0] a, b, x, y, r;
    glu_pkg::glu_rsp_t res;
    a = {32'd0, w.first_value} & OPERAND_MASK;
    b = {32'd0, w.second_value} & OPERAND_MASK;
    res.zero_operand = (a == 64'd0) || (b == 64'd0);
    if (res.zero_operand) begin
      res.result_value = (w.mode == glu_pkg::MODE_GCD) ? (a | b) : 64'd0;
    end else begin
      x = a;
      y = b;
      while (y != 64'd0) begin
        r = x % y;
        x = y;
        y = r;
      end
      res.result_value = (w.mode == glu_pkg::MODE_GCD) ? x : (a / x) * b;
    end
    return res;
  endfunction

  function automatic glu_pkg::glu_req_t random_word();
    glu_pkg::glu_req_t w;
    logic [31:0] g;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    w.mode = $urandom_range(0, 1) ? glu_pkg::MODE_LCM : glu_pkg::MODE_GCD;
    if (pick < 40) begin
      w.first_value = $urandom;
      w.second_value = $urandom;
    end else if (pick < 62) begin
      // common factor, so the divisor is a multiple of it
      g = $urandom_range(1, 65535);
      w.first_value = g * $urandom_range(1, 65535);
      w.second_value = g * $urandom_range(1, 65535);
    end else if (pick < 77) begin
      w.first_value = $urandom >> $urandom_range(0, 31);
      w.second_value = $urandom >> $urandom_range(0, 31);
    end else if (pick < 87) begin
      w.first_value = $urandom_range(0, 1) ? $urandom : 32'd0;
      w.second_value = (w.first_value == 32'd0 && $urandom_range(0, 1)) ? $urandom : 32'd0;
      if ($urandom_range(0, 1)) begin
        g = w.first_value;
        w.first_value = w.second_value;
        w.second_value = g;
      end
    end else if (pick < 94) begin
      w.first_value = $urandom >> $urandom_range(0, 16);
      w.second_value = $urandom_range(0, 1) ? w.first_value
                                            : w.first_value * $urandom_range(1, 3);
    end else begin
      case ($urandom_range(0, 3))
        0: w.first_value = 32'd1;
        1: w.first_value = 32'hFFFF_FFFF;
        2: w.first_value = 32'h8000_0000;
        default: w.first_value = $urandom;
      endcase
      w.second_value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
    end
    return w;
  endfunction

  task automatic add_word(input logic [31:0] a, input logic [31:0] b, input logic m);
    glu_pkg::glu_req_t w;
    w.first_value = a;
    w.second_value = b;
    w.mode = m;
    pending_words.push_back(w);
  endtask

  // hold until the sender is empty and every result is back
  task automatic wait_drained();
    while (pending_words.size() != 0 || req_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Sender: bursts of words separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (req_valid) expected_results.push_back(gcd_or_lcm(req));
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        req <= pending_words.pop_front();
        req_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
          case ($urandom_range(0, 7))
            0, 1, 2: gap_left = 0;
            7:       gap_left = $urandom_range(20, 60);
            default: gap_left = $urandom_range(1, 8);
          endcase
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver: stretches of different ready styles, plus occasional long hold-offs.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (hold_left == 0 && results_seen >= next_hold_at) begin
        hold_left = HOLD_OFF_CYCLES;
        next_hold_at += 550;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        if (style_span == 0) begin
          ready_style = ready_style_t'($urandom_range(0, 2));
          style_span = $urandom_range(16, 96);
        end
        style_span--;
        case (ready_style)
          READY_ALWAYS: rsp_ready <= 1'b1;
          READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
          default:      rsp_ready <= (style_span[1:0] == 2'd0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    glu_pkg::glu_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result word: result_value %0h zero_operand %0b",
               rsp.result_value, rsp.zero_operand);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (rsp.result_value !== want.result_value) begin
          $error("result_value: expected %0h, got %0h", want.result_value, rsp.result_value);
          mismatch_count++;
        end
        if (rsp.zero_operand !== want.zero_operand) begin
          $error("zero_operand: expected %0b, got %0b", want.zero_operand, rsp.zero_operand);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    // zero operands in both modes
    add_word(32'd0, 32'd0, glu_pkg::MODE_GCD);
    add_word(32'd0, 32'd0, glu_pkg::MODE_LCM);
    add_word(32'd0, 32'd12345, glu_pkg::MODE_GCD);
    add_word(32'hFFFF_FFFF, 32'd0, glu_pkg::MODE_GCD);
    add_word(32'd0, 32'hFFFF_FFFF, glu_pkg::MODE_LCM);
    add_word(32'd7, 32'd0, glu_pkg::MODE_LCM);
    // extremes and trivial divisors
    add_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, glu_pkg::MODE_GCD);
    add_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, glu_pkg::MODE_LCM);
    add_word(32'hFFFF_FFFF, 32'd1, glu_pkg::MODE_GCD);
    add_word(32'd1, 32'hFFFF_FFFF, glu_pkg::MODE_LCM);
    add_word(32'd1, 32'd1, glu_pkg::MODE_GCD);
    add_word(32'd1, 32'd1, glu_pkg::MODE_LCM);
    // two large primes: widest multiple
    add_word(32'd4294967291, 32'd4294967279, glu_pkg::MODE_LCM);
    add_word(32'd4294967291, 32'd4294967279, glu_pkg::MODE_GCD);
    add_word(32'h8000_0000, 32'h4000_0000, glu_pkg::MODE_GCD);
    add_word(32'h8000_0000, 32'hFFFF_FFFF, glu_pkg::MODE_LCM);
    // consecutive Fibonacci numbers: coprime operands
    add_word(32'd2971215073, 32'd1836311903, glu_pkg::MODE_GCD);
    add_word(32'd2971215073, 32'd1836311903, glu_pkg::MODE_LCM);
    add_word(32'd12, 32'd18, glu_pkg::MODE_GCD);
    add_word(32'd12, 32'd18, glu_pkg::MODE_LCM);
    add_word(32'hAAAA_AAAA, 32'h5555_5555, glu_pkg::MODE_GCD);
    add_word(32'hFFFF_FFFE, 32'h7FFF_FFFF, glu_pkg::MODE_LCM);
    wait_drained();

    repeat (550) pending_words.push_back(random_word());
    wait_drained();
    repeat (550) pending_words.push_back(random_word());
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS gcd_lcm_unit");
    end else begin
      $display("FAIL gcd_lcm_unit");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL gcd_lcm_unit");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/glu_pkg.sv
rtl/glu_sub.sv
rtl/glu_core.sv
rtl/gcd_lcm_unit.sv
tb/tb_top.sv
